// ===== rtl/core/mwma_pkg.sv =====
// shared constants, queue item type and width helpers for the weighted moving average unit
package mwma_pkg;

   // default configuration
   localparam int CHANNEL_COUNT_DEFAULT = 8;
   localparam int TAP_COUNT_DEFAULT     = 8;
   localparam int SAMPLE_BITS_DEFAULT   = 12;

   // fixed port field widths
   localparam int CHANNEL_W = 3;
   localparam int SAMPLE_W  = 12;

   // weight of the newest tap, older taps fall off linearly
   localparam int PEAK_WEIGHT = 128;
   localparam int WEIGHT_W    = $clog2(PEAK_WEIGHT + 1);

   // front to back queue depth
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0]  sample;
      logic                 in_range;
   } item_type;

   // stored sample width: only the low sample bits of the port are used
   function automatic int store_bits(input int sample_bits);
      return (sample_bits < SAMPLE_W) ? sample_bits : SAMPLE_W;
   endfunction

endpackage

// ===== rtl/core/mwma_front.sv =====
// front end: takes request beats, classifies the channel, masks the sample and queues the item
module mwma_front #(
   parameter int CHANNEL_COUNT = mwma_pkg::CHANNEL_COUNT_DEFAULT,
   parameter int SAMPLE_BITS   = mwma_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [mwma_pkg::CHANNEL_W-1:0] req_channel,
   input  logic [mwma_pkg::SAMPLE_W-1:0]  req_sample,
   output mwma_pkg::item_type             head,
   output logic                           head_valid,
   input  logic                           pop
);

   localparam int STORE_BITS = mwma_pkg::store_bits(SAMPLE_BITS);
   localparam int IDX_BITS   = $clog2(mwma_pkg::QUEUE_DEPTH);
   localparam int CNT_BITS   = $clog2(mwma_pkg::QUEUE_DEPTH + 1);
   localparam logic [mwma_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
      mwma_pkg::SAMPLE_W'((2 ** STORE_BITS) - 1);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(mwma_pkg::QUEUE_DEPTH);

   mwma_pkg::item_type queue_ff [mwma_pkg::QUEUE_DEPTH];
   mwma_pkg::item_type item_in;
   logic [IDX_BITS-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_BITS-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push;
   logic                pull;

   // classify and mask
   always_comb begin
      item_in.channel  = req_channel;
      item_in.sample   = req_sample & SAMPLE_MASK;
      item_in.in_range = (32'(req_channel) < CHANNEL_COUNT);
   end

   assign req_stall  = (count_ff == FULL_COUNT);
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != '0);
   assign pull       = pop && head_valid;
   assign head       = queue_ff[rd_idx_ff];

   always_comb begin
      wr_idx_in = push ? IDX_BITS'(wr_idx_ff + IDX_BITS'(1)) : wr_idx_ff;
      rd_idx_in = pull ? IDX_BITS'(rd_idx_ff + IDX_BITS'(1)) : rd_idx_ff;
      count_in  = count_ff;
      if (push && !pull) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pull && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_idx_ff] <= item_in;
      end
   end

endmodule

// ===== rtl/core/mwma_back.sv =====
// back end: tap history memory, serial multiply-accumulate, constant divider and result register
module mwma_back #(
   parameter int CHANNEL_COUNT = mwma_pkg::CHANNEL_COUNT_DEFAULT,
   parameter int TAP_COUNT     = mwma_pkg::TAP_COUNT_DEFAULT,
   parameter int SAMPLE_BITS   = mwma_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mwma_pkg::item_type             head,
   input  logic                           head_valid,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mwma_pkg::CHANNEL_W-1:0] rsp_channel_out,
   output logic [mwma_pkg::SAMPLE_W-1:0]  rsp_filtered
);

   localparam int STORE_BITS = mwma_pkg::store_bits(SAMPLE_BITS);
   localparam int AGE_BITS   = $clog2(TAP_COUNT);
   localparam int CH_BITS    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int MEM_DEPTH  = CHANNEL_COUNT * TAP_COUNT;
   localparam int ADDR_BITS  = $clog2(MEM_DEPTH);
   localparam int WEIGHT_W   = mwma_pkg::WEIGHT_W;
   localparam int PROD_BITS  = STORE_BITS + WEIGHT_W;

   typedef logic [TAP_COUNT-1:0][WEIGHT_W-1:0] weight_table_type;

   // weight of age position k (oldest first), truncated
   function automatic weight_table_type build_weights();
      weight_table_type tbl;
      for (int k = 0; k < TAP_COUNT; k++) begin
         tbl[k] = WEIGHT_W'(((k + 1) * mwma_pkg::PEAK_WEIGHT) / TAP_COUNT);
      end
      return tbl;
   endfunction

   function automatic int sum_weights();
      int s;
      s = 0;
      for (int k = 0; k < TAP_COUNT; k++) begin
         s = s + ((k + 1) * mwma_pkg::PEAK_WEIGHT) / TAP_COUNT;
      end
      return s;
   endfunction

   localparam weight_table_type WEIGHTS = build_weights();
   localparam int WEIGHT_TOTAL = sum_weights();
   localparam int ACC_BITS     = $clog2(((2 ** STORE_BITS) - 1) * WEIGHT_TOTAL + 1);
   // rounded-up reciprocal of the weight total, exact over the whole accumulator range
   localparam int DIV_SHIFT    = ACC_BITS + $clog2(WEIGHT_TOTAL);
   localparam int RECIP_BITS   = ACC_BITS + 2;
   localparam int SCALED_BITS  = ACC_BITS + RECIP_BITS;
   localparam logic [AGE_BITS-1:0]   LAST_AGE = AGE_BITS'(TAP_COUNT - 1);
   localparam logic [RECIP_BITS-1:0] RECIP    = RECIP_BITS'(
      ((64'd1 << DIV_SHIFT) + 64'(WEIGHT_TOTAL) - 64'd1) / 64'(WEIGHT_TOTAL));

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MAC    = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_DONE   = 4'b1000
   } back_state_type;

   function automatic logic [ADDR_BITS-1:0] tap_addr(input logic [CH_BITS-1:0]  ch,
                                                     input logic [AGE_BITS-1:0] slot);
      return ADDR_BITS'(ADDR_BITS'(ch) * ADDR_BITS'(TAP_COUNT) + ADDR_BITS'(slot));
   endfunction

   function automatic logic [AGE_BITS-1:0] next_slot(input logic [AGE_BITS-1:0] slot);
      return (slot == LAST_AGE) ? '0 : AGE_BITS'(slot + AGE_BITS'(1));
   endfunction

   back_state_type state_ff, state_in;

   logic [STORE_BITS-1:0]         tap_mem [MEM_DEPTH];
   logic [STORE_BITS-1:0]         rd_data_ff;
   logic [ADDR_BITS-1:0]          rd_addr;
   logic [ADDR_BITS-1:0]          wr_addr;
   logic                          mem_wr_en;

   logic [AGE_BITS-1:0]           ptr_ff [CHANNEL_COUNT];
   logic [CHANNEL_COUNT-1:0]      wrapped_ff;
   logic                          ptr_wr_en;
   logic [CH_BITS-1:0]            head_ch_idx;
   logic [AGE_BITS-1:0]           head_ptr;
   logic                          head_wrapped;
   logic [STORE_BITS-1:0]         head_sample;

   logic [mwma_pkg::CHANNEL_W-1:0] ch_ff, ch_in;
   logic [CH_BITS-1:0]            ch_idx;
   logic [AGE_BITS-1:0]           ptr_old_ff, ptr_old_in;
   logic                          wrapped_old_ff, wrapped_old_in;
   logic [AGE_BITS-1:0]           slot_ff, slot_in;
   logic [AGE_BITS-1:0]           age_ff, age_in;
   logic                          s1_valid_ff, s1_valid_in;
   logic [AGE_BITS-1:0]           s1_age_ff, s1_age_in;
   logic                          s1_live_ff, s1_live_in;
   logic [ACC_BITS-1:0]           acc_ff, acc_in;
   logic [STORE_BITS-1:0]         mac_operand;
   logic [PROD_BITS-1:0]          product;
   logic [PROD_BITS-1:0]          newest_product;

   logic [STORE_BITS-1:0]         quo_ff, quo_in;
   logic [SCALED_BITS-1:0]        scaled;

   logic                          rsp_load;
   logic                          rsp_valid_ff;
   logic [mwma_pkg::CHANNEL_W-1:0] rsp_channel_ff;
   logic [STORE_BITS-1:0]         rsp_filtered_ff;

   // per channel ring state of the item at the head of the queue
   assign head_ch_idx  = CH_BITS'(head.channel);
   assign head_ptr     = ptr_ff[head_ch_idx];
   assign head_wrapped = wrapped_ff[head_ch_idx];
   assign head_sample  = head.sample[STORE_BITS-1:0];
   assign wr_addr      = tap_addr(head_ch_idx, head_ptr);
   assign ch_idx       = CH_BITS'(ch_ff);
   assign rd_addr      = tap_addr(ch_idx, slot_ff);

   // taps never written since reset read as zero
   assign mac_operand    = s1_live_ff ? rd_data_ff : '0;
   assign product        = PROD_BITS'(mac_operand) * PROD_BITS'(WEIGHTS[s1_age_ff]);
   assign newest_product = PROD_BITS'(head_sample) * PROD_BITS'(WEIGHTS[LAST_AGE]);

   // divide by the constant weight total through its reciprocal
   assign scaled = SCALED_BITS'(acc_ff) * SCALED_BITS'(RECIP);

   always_comb begin
      state_in       = state_ff;
      ch_in          = ch_ff;
      ptr_old_in     = ptr_old_ff;
      wrapped_old_in = wrapped_old_ff;
      slot_in        = slot_ff;
      age_in         = age_ff;
      s1_valid_in    = 1'b0;
      s1_age_in      = age_ff;
      s1_live_in     = wrapped_old_ff || (slot_ff < ptr_old_ff);
      acc_in         = acc_ff;
      quo_in         = quo_ff;
      pop            = 1'b0;
      mem_wr_en      = 1'b0;
      ptr_wr_en      = 1'b0;
      rsp_load       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop   = 1'b1;
               ch_in = head.channel;
               if (head.in_range) begin
                  mem_wr_en      = 1'b1;
                  ptr_wr_en      = 1'b1;
                  ptr_old_in     = head_ptr;
                  wrapped_old_in = head_wrapped;
                  slot_in        = next_slot(head_ptr);
                  age_in         = '0;
                  acc_in         = ACC_BITS'(newest_product);
                  state_in       = ST_MAC;
               end else begin
                  quo_in   = '0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_MAC: begin
            if (s1_valid_ff) begin
               acc_in = ACC_BITS'(acc_ff + ACC_BITS'(product));
            end
            if (age_ff != LAST_AGE) begin
               s1_valid_in = 1'b1;
               age_in      = AGE_BITS'(age_ff + AGE_BITS'(1));
               slot_in     = next_slot(slot_ff);
            end else if (!s1_valid_ff) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            quo_in   = STORE_BITS'(scaled >> DIV_SHIFT);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wrapped_ff   <= '0;
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            ptr_ff[c] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= s1_valid_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ptr_wr_en) begin
            ptr_ff[head_ch_idx] <= next_slot(head_ptr);
            if (head_ptr == LAST_AGE) begin
               wrapped_ff[head_ch_idx] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      ch_ff          <= ch_in;
      ptr_old_ff     <= ptr_old_in;
      wrapped_old_ff <= wrapped_old_in;
      slot_ff        <= slot_in;
      age_ff         <= age_in;
      s1_age_ff      <= s1_age_in;
      s1_live_ff     <= s1_live_in;
      acc_ff         <= acc_in;
      quo_ff         <= quo_in;
      if (rsp_load) begin
         rsp_channel_ff  <= ch_ff;
         rsp_filtered_ff <= quo_ff;
      end
   end

   // tap history, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         tap_mem[wr_addr] <= head_sample;
      end
      rd_data_ff <= tap_mem[rd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_out = rsp_channel_ff;
   assign rsp_filtered    = mwma_pkg::SAMPLE_W'(rsp_filtered_ff);

endmodule

// ===== rtl/core/multichannel_weighted_moving_average_unit.sv =====
// Multichannel linear weighted moving average: each request beat carries a channel and a
// converter sample; the sample goes into that channel's ring of TAP_COUNT taps and the unit
// returns one response beat with the channel and the weighted mean of the ring, the newest
// tap weighted PEAK_WEIGHT and each older tap a linear step less, truncated. Channels at or
// above CHANNEL_COUNT leave all state alone and return a filtered value of zero. Bits of the
// sample above SAMPLE_BITS are ignored. Ring pointers start at zero after reset and the tap history
// is not cleared; a per channel wrap flag marks taps never written, which read as zero, so there is no
// clearing pass and the unit is ready in the first cycle after reset. Items are worked one at
// a time: an in-range item has its tap written and its newest product formed, then the single
// read port of the tap memory feeds one multiply-accumulate per older tap, then the sum is
// divided by the constant weight total through a reciprocal multiply and the response register
// is loaded; an out-of-range item goes straight to loading the response. A two-beat queue in
// front and a response register at the back keep both sides flowing while the other stalls.
module multichannel_weighted_moving_average_unit #(
   parameter int CHANNEL_COUNT = mwma_pkg::CHANNEL_COUNT_DEFAULT,
   parameter int TAP_COUNT     = mwma_pkg::TAP_COUNT_DEFAULT,
   parameter int SAMPLE_BITS   = mwma_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [mwma_pkg::CHANNEL_W-1:0] req_channel,
   input  logic [mwma_pkg::SAMPLE_W-1:0]  req_sample,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mwma_pkg::CHANNEL_W-1:0] rsp_channel_out,
   output logic [mwma_pkg::SAMPLE_W-1:0]  rsp_filtered
);

   // queue head handed from front to back
   mwma_pkg::item_type head;
   logic               head_valid;
   logic               pop;

   // front: classify channel, mask sample, queue the beat
   mwma_front #(
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_channel (req_channel),
      .req_sample  (req_sample),
      .head        (head),
      .head_valid  (head_valid),
      .pop         (pop)
   );

   // back: write the tap, accumulate the newest tap then the rest oldest first, divide, hold the response
   mwma_back #(
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .TAP_COUNT     (TAP_COUNT),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .head_valid      (head_valid),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_channel_out (rsp_channel_out),
      .rsp_filtered    (rsp_filtered)
   );

endmodule

// ===== rtl/core/mwma_checker.sv =====
// port level checks for the weighted moving average unit and their bind
module mwma_checker #(
   parameter int CHANNEL_COUNT = mwma_pkg::CHANNEL_COUNT_DEFAULT,
   parameter int SAMPLE_BITS   = mwma_pkg::SAMPLE_BITS_DEFAULT
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [mwma_pkg::CHANNEL_W-1:0] rsp_channel_out,
   input logic [mwma_pkg::SAMPLE_W-1:0]  rsp_filtered
);

   localparam int STORE_BITS = mwma_pkg::store_bits(SAMPLE_BITS);
   localparam logic [mwma_pkg::SAMPLE_W-1:0] FILTER_MAX =
      mwma_pkg::SAMPLE_W'((2 ** STORE_BITS) - 1);

   // beats taken in but not yet answered
   logic [3:0] outstanding_ff;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else if (req_beat && !rsp_beat) begin
         outstanding_ff <= outstanding_ff + 4'd1;
      end else if (rsp_beat && !req_beat) begin
         outstanding_ff <= outstanding_ff - 4'd1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_channel_out) && $stable(rsp_filtered))
      else $error("response beat dropped or changed while stalled");

   a_bad_channel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (32'(rsp_channel_out) >= CHANNEL_COUNT) |-> rsp_filtered == '0)
      else $error("unused channel returned a non-zero value");

   a_filtered_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_filtered <= FILTER_MAX)
      else $error("filtered value exceeds the sample range");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != '0)
      else $error("response beat without a pending request");

   a_reset_state: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("unit not empty after reset");

endmodule

bind multichannel_weighted_moving_average_unit mwma_checker #(
   .CHANNEL_COUNT (CHANNEL_COUNT),
   .SAMPLE_BITS   (SAMPLE_BITS)
) u_mwma_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_channel_out (rsp_channel_out),
   .rsp_filtered    (rsp_filtered)
);

// ===== dv/multichannel_weighted_moving_average_unit_tb.sv =====
// self-checking testbench for the multichannel weighted moving average unit
module multichannel_weighted_moving_average_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHANNEL_W   = mwma_pkg::CHANNEL_W;
   localparam int SAMPLE_W    = mwma_pkg::SAMPLE_W;
   localparam int PEAK_WEIGHT = mwma_pkg::PEAK_WEIGHT;
   localparam int CHANNELS    = mwma_pkg::CHANNEL_COUNT_DEFAULT;
   localparam int TAPS        = mwma_pkg::TAP_COUNT_DEFAULT;
   localparam int SAMPLE_BITS = mwma_pkg::SAMPLE_BITS_DEFAULT;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

   localparam int RANDOM_BEATS   = 730;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_CYCLES   = 60;
   localparam int REPORT_LIMIT   = 10;
   localparam int DIRECTED_COUNT = 20;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0]  filtered;
   } average_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0]  sample;
      logic                 typed;     // expected value written in the row
      logic [SAMPLE_W-1:0]  filtered;
   } stim_row_type;

   logic                 clock;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   logic [CHANNEL_W-1:0] req_channel = '0;
   logic [SAMPLE_W-1:0]  req_sample  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   logic [CHANNEL_W-1:0] rsp_channel_out;
   logic [SAMPLE_W-1:0]  rsp_filtered;

   multichannel_weighted_moving_average_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_channel_out (rsp_channel_out),
      .rsp_filtered    (rsp_filtered)
   );

   // predictor state: tap rings and write pointers per channel
   logic [SAMPLE_W-1:0] tap_ring [CHANNELS][TAPS];
   int unsigned         ring_ptr [CHANNELS];

   average_type pending_averages [$];
   int          error_count    = 0;
   int          mismatch_count = 0;
   int          cycle_count    = 0;
   bit          hold_request   = 1'b0;

   // directed rows: first sample after reset, a full ring of peaks, bit patterns
   stim_row_type directed_rows [DIRECTED_COUNT] = '{
      '{3'd0, 12'hFFF, 1'b1, 12'd910},   // lone peak against reset zeros
      '{3'd1, 12'h000, 1'b1, 12'd0},
      '{3'd0, 12'hFFF, 1'b0, 12'd0},
      '{3'd7, 12'hFFF, 1'b0, 12'd0},
      '{3'd7, 12'hFFF, 1'b0, 12'd0},
      '{3'd7, 12'hFFF, 1'b0, 12'd0},
      '{3'd7, 12'hFFF, 1'b0, 12'd0},
      '{3'd7, 12'hFFF, 1'b0, 12'd0},
      '{3'd7, 12'hFFF, 1'b0, 12'd0},
      '{3'd7, 12'hFFF, 1'b0, 12'd0},
      '{3'd7, 12'hFFF, 1'b1, 12'd4095},  // ring full of peaks
      '{3'd7, 12'h000, 1'b0, 12'd0},
      '{3'd2, 12'hAAA, 1'b0, 12'd0},
      '{3'd3, 12'h555, 1'b0, 12'd0},
      '{3'd4, 12'h001, 1'b0, 12'd0},
      '{3'd5, 12'h800, 1'b0, 12'd0},
      '{3'd6, 12'h7FF, 1'b0, 12'd0},
      '{3'd1, 12'h000, 1'b1, 12'd0},     // channel still all zero
      '{3'd6, 12'hFFF, 1'b0, 12'd0},
      '{3'd0, 12'h000, 1'b0, 12'd0}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("multichannel_weighted_moving_average_unit_tb: errors");
         $finish;
      end
   end

   // writes the sample into the ring and returns the weighted mean, oldest tap first
   function automatic logic [SAMPLE_W-1:0] weighted_average(
      input logic [CHANNEL_W-1:0] ch,
      input logic [SAMPLE_W-1:0]  smp
   );
      int unsigned ptr;
      int unsigned slot;
      int unsigned weight;
      int unsigned acc;
      int unsigned weight_total;
      acc          = 0;
      weight_total = 0;
      if (int'(ch) >= CHANNELS) return '0;
      ptr = ring_ptr[ch] % TAPS;
      tap_ring[ch][ptr] = smp & SAMPLE_MASK;
      for (int unsigned age = 0; age < TAPS; age++) begin
         slot          = (ptr + age + 1) % TAPS;
         weight        = ((age + 1) * PEAK_WEIGHT) / TAPS;
         acc          += tap_ring[ch][slot] * weight;
         weight_total += weight;
      end
      ring_ptr[ch] = (ptr + 1) % TAPS;
      return (weight_total != 0) ? SAMPLE_W'(acc / weight_total) & SAMPLE_MASK : '0;
   endfunction

   // offers one beat and waits for it to be taken; valid stays high on return
   task automatic offer_beat(input logic [CHANNEL_W-1:0] ch, input logic [SAMPLE_W-1:0] smp,
                             input logic typed, input logic [SAMPLE_W-1:0] typed_value);
      average_type         avg;
      logic [SAMPLE_W-1:0] predicted;
      req_valid   <= 1'b1;
      req_channel <= ch;
      req_sample  <= smp;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted    = weighted_average(ch, smp);
      avg.channel  = ch;
      avg.filtered = typed ? typed_value : predicted;
      pending_averages.push_back(avg);
   endtask

   task automatic sender_gap(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return SAMPLE_W'($urandom_range(0, 15));
         3:       return SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
         4:       return SAMPLE_W'(4095 - $urandom_range(0, 15));
         default: return SAMPLE_W'($urandom_range(0, 4095));
      endcase
   endfunction

   // receiver: stall pattern changes mode every so often; long hold-off on request
   int rx_mode     = 0;
   int rx_mode_left = 0;
   int rx_hold_left = 0;
   always @(posedge clock) begin
      logic stall_next;
      if (hold_request && rx_hold_left == 0) begin
         rx_hold_left = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (rx_mode_left == 0) begin
         rx_mode      = $urandom_range(0, 3);
         rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         stall_next = 1'b1;
      end else begin
         case (rx_mode)
            0:       stall_next = 1'b0;
            1:       stall_next = ($urandom_range(0, 9) < 3);
            2:       stall_next = ($urandom_range(0, 9) < 7);
            default: stall_next = (cycle_count % 5) < 2;
         endcase
      end
      rsp_stall <= stall_next;
   end

   // result checker against the oldest expectation
   always @(posedge clock) begin
      average_type avg;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_averages.size() == 0) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected beat: channel %0d filtered %0d", rsp_channel_out,
                        rsp_filtered);
         end else begin
            avg = pending_averages.pop_front();
            if (rsp_channel_out !== avg.channel || rsp_filtered !== avg.filtered) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("mismatch: expected channel %0d filtered %0d, %s %0d filtered %0d",
                           avg.channel, avg.filtered, "got channel", rsp_channel_out,
                           rsp_filtered);
            end
         end
      end
   end

   initial begin
      int                   burst_left;
      int                   sent;
      bit                   sticky;
      logic [CHANNEL_W-1:0] burst_channel;
      logic [CHANNEL_W-1:0] ch;
      for (int c = 0; c < CHANNELS; c++) begin
         ring_ptr[c] = 0;
         for (int t = 0; t < TAPS; t++) tap_ring[c][t] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part, with a short gap now and then
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         offer_beat(directed_rows[i].channel, directed_rows[i].sample,
                    directed_rows[i].typed, directed_rows[i].filtered);
         sender_gap((i % 4 == 3) ? $urandom_range(1, 6) : 0);
      end

      // random part in bursts; some bursts stay on one channel to walk its ring
      sent       = 0;
      burst_left = 0;
      while (sent < RANDOM_BEATS) begin
         if (burst_left == 0) begin
            burst_left    = $urandom_range(1, 24);
            sticky        = ($urandom_range(0, 2) == 0);
            burst_channel = CHANNEL_W'($urandom_range(0, 7));
            sender_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
         end
         if (sent == 200) hold_request = 1'b1;      // block fills and stalls its input
         if (sent == 450 && pending_averages.size() != 0) begin
            // pause until every outstanding result is back
            req_valid <= 1'b0;
            while (pending_averages.size() != 0) @(posedge clock);
         end
         ch = sticky ? burst_channel : CHANNEL_W'($urandom_range(0, 7));
         offer_beat(ch, random_sample(), 1'b0, '0);
         sent++;
         burst_left--;
         if (burst_left != 0 && $urandom_range(0, 4) == 0) sender_gap($urandom_range(1, 8));
      end
      req_valid <= 1'b0;

      while (pending_averages.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_averages.size() == 0) begin
         $display("multichannel_weighted_moving_average_unit_tb: clean");
      end else begin
         $display("multichannel_weighted_moving_average_unit_tb: errors");
      end
      $finish;
   end

endmodule
